FILE: sv/pcmt_pkg.sv
// Shared types and constants for the priority command mux with source timeouts.
// Holds the request structs, the configuration register map and default sizes.
// No dependencies.
package pcmt_pkg;

    // Fixed field widths
    localparam int SRC_W        = 3;
    localparam int SRC_SLOTS    = 8;
    localparam int PAYLOAD_W    = 64;
    localparam int COUNT_W      = 4;
    localparam int PRIO_TABLE_W = 32;
    localparam int TMO_WORD_W   = 128;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 64;

    // Default sizes
    localparam int DEF_NUM_SOURCES   = 8;
    localparam int DEF_TIMEOUT_BITS  = 16;
    localparam int DEF_PRIORITY_BITS = 4;

    // Action codes
    localparam logic ACT_COMMAND = 1'b0;
    localparam logic ACT_TICK    = 1'b1;

    // Register map
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SOURCES_IN_USE = 2'd0,
        CFG_PRIORITY_TABLE = 2'd1,
        CFG_TIMEOUTS_LOW   = 2'd2,
        CFG_TIMEOUTS_HIGH  = 2'd3
    } cfg_reg_t;

    // Input request
    typedef struct packed {
        logic                 action;
        logic [SRC_W-1:0]     source;
        logic [PAYLOAD_W-1:0] payload;
    } in_item_t;

    // Result request
    typedef struct packed {
        logic                 forward;
        logic [PAYLOAD_W-1:0] out_payload;
        logic                 owner_changed;
        logic                 owner_valid;
        logic [SRC_W-1:0]     owner;
        logic                 went_idle;
        logic                 by_global_timeout;
        logic                 bad_source;
    } result_t;

endpackage

FILE: sv/priority_command_mux_timeout.sv
// Priority command mux with per-source and global tick timeouts.
// Depends on pcmt_pkg (request structs, register map, default sizes).
//
// Usage:
//   Input channel in_valid / in_stall / in_item carries either a command
//   (action = command, with source and payload) or one time tick. Output
//   channel out_valid / out_stall / out_item returns exactly one result per
//   request: forward flag and payload, ownership change, current owner,
//   idle and bad-source flags.
//   Configuration is a plain write port (cfg_write, cfg_index, cfg_data). The
//   user must write it only while no request is in flight; nothing checks it.
// Timing:
//   A request is registered on acceptance and evaluated against the owner
//   and countdown state in the following cycle. The result, owner and countdown
//   registers load together when the result register is empty or being taken.
//   One request per cycle is sustained while out_stall stays low. The longest
//   in-use timeout is held in a register refreshed every cycle from the
//   configuration.
// Reset and stall:
//   Reset vacates the owner, stops both countdowns and clears all config
//   registers. While out_stall holds a result, one more request is taken
//   into the input register and then in_stall rises.
module priority_command_mux_timeout #(
    parameter int NUM_SOURCES   = pcmt_pkg::DEF_NUM_SOURCES,
    parameter int TIMEOUT_BITS  = pcmt_pkg::DEF_TIMEOUT_BITS,
    parameter int PRIORITY_BITS = pcmt_pkg::DEF_PRIORITY_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration write port
    input  logic                            cfg_write,
    input  logic [pcmt_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [pcmt_pkg::CFG_DATA_W-1:0]  cfg_data,
    // input channel
    input  logic                            in_valid,
    output logic                            in_stall,
    input  pcmt_pkg::in_item_t              in_item,
    // output channel
    output logic                            out_valid,
    input  logic                            out_stall,
    output pcmt_pkg::result_t               out_item
);

    localparam int TBL    = (NUM_SOURCES > pcmt_pkg::SRC_SLOTS) ? NUM_SOURCES
                                                                : pcmt_pkg::SRC_SLOTS;
    localparam int TIDX_W = $clog2(TBL);
    localparam int GCD_W  = TIMEOUT_BITS + 1;

    // Configuration registers
    logic [pcmt_pkg::COUNT_W-1:0]      sources_in_use_reg;
    logic [pcmt_pkg::PRIO_TABLE_W-1:0] priority_table_reg;
    logic [pcmt_pkg::CFG_DATA_W-1:0]   timeouts_low_reg;
    logic [pcmt_pkg::CFG_DATA_W-1:0]   timeouts_high_reg;

    // Pipeline registers
    logic                s1_valid_reg;
    pcmt_pkg::in_item_t  s1_item_reg;
    logic                out_valid_reg;
    pcmt_pkg::result_t   out_item_reg;
    logic                s1_fire;

    // Arbitration state
    logic                         owner_held_reg, owner_held_next;
    logic [pcmt_pkg::SRC_W-1:0]   owner_reg, owner_next;
    logic [TIMEOUT_BITS-1:0]      owner_cd_reg, owner_cd_next;
    logic [GCD_W-1:0]             global_cd_reg, global_cd_next;
    logic                         global_run_reg, global_run_next;
    logic [TIMEOUT_BITS-1:0]      longest_reg, longest_next;
    pcmt_pkg::result_t            result_next;

    // Unpacked config tables
    logic [pcmt_pkg::TMO_WORD_W-1:0] tmo_word;
    logic [TIMEOUT_BITS-1:0]         tmo_arr  [TBL];
    logic [PRIORITY_BITS-1:0]        prio_arr [pcmt_pkg::SRC_SLOTS];

    // Handshake: the input register drains into the result register
    assign s1_fire   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !s1_fire;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // Config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sources_in_use_reg <= '0;
            priority_table_reg <= '0;
            timeouts_low_reg   <= '0;
            timeouts_high_reg  <= '0;
        end
        else if (cfg_write)
        begin
            unique case (pcmt_pkg::cfg_reg_t'(cfg_index))
                pcmt_pkg::CFG_SOURCES_IN_USE:
                    sources_in_use_reg <= cfg_data[pcmt_pkg::COUNT_W-1:0];
                pcmt_pkg::CFG_PRIORITY_TABLE:
                    priority_table_reg <= cfg_data[pcmt_pkg::PRIO_TABLE_W-1:0];
                pcmt_pkg::CFG_TIMEOUTS_LOW:
                    timeouts_low_reg <= cfg_data;
                pcmt_pkg::CFG_TIMEOUTS_HIGH:
                    timeouts_high_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Split config words into per-source fields; bits past the word read zero
    assign tmo_word = {timeouts_high_reg, timeouts_low_reg};

    always_comb
    begin
        int p;
        for (int i = 0; i < TBL; i++)
        begin
            for (int b = 0; b < TIMEOUT_BITS; b++)
            begin
                p = i * TIMEOUT_BITS + b;
                tmo_arr[i][b] = (p < pcmt_pkg::TMO_WORD_W) ? tmo_word[p[6:0]] : 1'b0;
            end
        end
        for (int s = 0; s < pcmt_pkg::SRC_SLOTS; s++)
        begin
            for (int b = 0; b < PRIORITY_BITS; b++)
            begin
                p = s * PRIORITY_BITS + b;
                prio_arr[s][b] = (p < pcmt_pkg::PRIO_TABLE_W)
                               ? priority_table_reg[p[4:0]] : 1'b0;
            end
        end
    end

    // Longest timeout among sources in use, refreshed each cycle
    always_comb
    begin
        longest_next = '0;
        for (int i = 0; i < NUM_SOURCES; i++)
        begin
            if ((i < 32'(sources_in_use_reg)) && (tmo_arr[i] > longest_next))
                longest_next = tmo_arr[i];
        end
    end

    // Evaluate the registered request against the arbitration state
    always_comb
    begin
        logic                       is_tick;
        logic [pcmt_pkg::SRC_W-1:0] src;
        logic                       src_ok;
        logic                       take;
        logic                       own_exp;
        logic                       glob_exp;

        is_tick  = (s1_item_reg.action == pcmt_pkg::ACT_TICK);
        src      = s1_item_reg.source;
        src_ok   = (32'(src) < NUM_SOURCES) && ({1'b0, src} < sources_in_use_reg);
        take     = 1'b0;
        own_exp  = 1'b0;
        glob_exp = 1'b0;

        owner_held_next = owner_held_reg;
        owner_next      = owner_reg;
        owner_cd_next   = owner_cd_reg;
        global_cd_next  = global_cd_reg;
        global_run_next = global_run_reg;
        result_next     = '0;

        if (!is_tick)
        begin
            if (!src_ok)
            begin
                result_next.bad_source = 1'b1;
            end
            else
            begin
                global_cd_next  = {longest_reg, 1'b0};
                global_run_next = 1'b1;
                take = !owner_held_reg || (owner_reg == src)
                     || (prio_arr[src] > prio_arr[owner_reg]);
                if (take)
                begin
                    result_next.owner_changed = !owner_held_reg || (owner_reg != src);
                    result_next.forward       = 1'b1;
                    result_next.out_payload   = s1_item_reg.payload;
                    owner_held_next = 1'b1;
                    owner_next      = src;
                    owner_cd_next   = tmo_arr[TIDX_W'(src)];
                end
            end
        end
        else
        begin
            // owner countdown
            if (owner_held_reg)
            begin
                if (owner_cd_reg <= TIMEOUT_BITS'(1))
                    own_exp = 1'b1;
                else
                    owner_cd_next = owner_cd_reg - TIMEOUT_BITS'(1);
            end
            // global countdown
            if (global_run_reg)
            begin
                if (global_cd_reg <= GCD_W'(1))
                begin
                    glob_exp        = 1'b1;
                    global_run_next = 1'b0;
                    global_cd_next  = '0;
                end
                else
                begin
                    global_cd_next = global_cd_reg - GCD_W'(1);
                end
            end
            // vacate; owner expiry wins the flag
            if (owner_held_reg && (own_exp || glob_exp))
            begin
                result_next.went_idle         = 1'b1;
                result_next.by_global_timeout = !own_exp;
                owner_held_next = 1'b0;
                owner_next      = '0;
                owner_cd_next   = '0;
            end
        end

        result_next.owner_valid = owner_held_next;
        result_next.owner       = owner_held_next ? owner_next : '0;
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            owner_held_reg <= 1'b0;
            owner_reg      <= '0;
            owner_cd_reg   <= '0;
            global_cd_reg  <= '0;
            global_run_reg <= 1'b0;
            longest_reg    <= '0;
        end
        else
        begin
            longest_reg <= longest_next;
            if (in_valid && !in_stall)
                s1_valid_reg <= 1'b1;
            else if (s1_fire)
                s1_valid_reg <= 1'b0;

            if (s1_fire)
            begin
                out_valid_reg  <= 1'b1;
                owner_held_reg <= owner_held_next;
                owner_reg      <= owner_next;
                owner_cd_reg   <= owner_cd_next;
                global_cd_reg  <= global_cd_next;
                global_run_reg <= global_run_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            s1_item_reg <= in_item;
        if (s1_fire)
            out_item_reg <= result_next;
    end

    // A vacant owner never carries a running countdown
    a_vacant_cd_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !owner_held_reg |-> (owner_cd_reg == '0))
        else $error("owner countdown nonzero while vacant");

    // A stopped global countdown is parked at zero
    a_global_stopped: assert property (@(posedge clk) disable iff (!rst_n)
        !global_run_reg |-> (global_cd_reg == '0))
        else $error("global countdown nonzero while stopped");

    // A held result blocks a full input register
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall && s1_valid_reg) |-> in_stall)
        else $error("input accepted past a stalled result");

    // An ownership change is always a forwarded command with a valid owner
    a_change_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_item_reg.owner_changed)
            |-> (out_item_reg.forward && out_item_reg.owner_valid
                 && !out_item_reg.went_idle))
        else $error("owner change without forward");

    // Vacating leaves the output without an owner
    a_idle_vacant: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_item_reg.went_idle) |-> !out_item_reg.owner_valid)
        else $error("went idle but owner still valid");

endmodule

FILE: dv/tb_priority_command_mux_timeout.sv
// Testbench for priority_command_mux_timeout: ownership, preemption, timeouts, bad sources.
// Predicts every result in a scoreboard class and checks it in order of arrival.
// Depends on pcmt_pkg and the priority_command_mux_timeout RTL.
module tb_priority_command_mux_timeout;

    // cycles without any accepted request or taken result before the run is abandoned
    localparam int STALL_LIMIT = 2000;
    localparam int TBITS       = pcmt_pkg::DEF_TIMEOUT_BITS;
    localparam int PBITS       = pcmt_pkg::DEF_PRIORITY_BITS;
    localparam int NSRC        = pcmt_pkg::DEF_NUM_SOURCES;

    // Expected-result store plus its own copy of the mux state
    class ownership_scoreboard;
        logic [pcmt_pkg::COUNT_W-1:0]      src_count;
        logic [pcmt_pkg::PRIO_TABLE_W-1:0] prio_table;
        logic [pcmt_pkg::CFG_DATA_W-1:0]   tmo_low;
        logic [pcmt_pkg::CFG_DATA_W-1:0]   tmo_high;

        bit                            holding;
        logic [pcmt_pkg::SRC_W-1:0]    holder;
        logic [TBITS-1:0]              holder_left;
        logic [TBITS:0]                all_left;
        bit                            all_running;

        pcmt_pkg::result_t expected_results[$];
        int                errors;
        int                checked;

        function new();
            src_count   = '0;
            prio_table  = '0;
            tmo_low     = '0;
            tmo_high    = '0;
            holding     = 1'b0;
            holder      = '0;
            holder_left = '0;
            all_left    = '0;
            all_running = 1'b0;
            errors      = 0;
            checked     = 0;
        endfunction

        function void set_reg(pcmt_pkg::cfg_reg_t idx, logic [pcmt_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                pcmt_pkg::CFG_SOURCES_IN_USE: src_count  = data[pcmt_pkg::COUNT_W-1:0];
                pcmt_pkg::CFG_PRIORITY_TABLE: prio_table = data[pcmt_pkg::PRIO_TABLE_W-1:0];
                pcmt_pkg::CFG_TIMEOUTS_LOW:   tmo_low    = data;
                pcmt_pkg::CFG_TIMEOUTS_HIGH:  tmo_high   = data;
                default: ;
            endcase
        endfunction

        function int active_sources();
            return (src_count > NSRC) ? NSRC : int'(src_count);
        endfunction

        function logic [PBITS-1:0] prio_of(int s);
            return prio_table[s*PBITS +: PBITS];
        endfunction

        function logic [TBITS-1:0] timeout_of(int s);
            logic [pcmt_pkg::TMO_WORD_W-1:0] word;
            word = {tmo_high, tmo_low};
            return word[s*TBITS +: TBITS];
        endfunction

        // Advance the state by one request and return what the mux should report
        function pcmt_pkg::result_t predict_result(pcmt_pkg::in_item_t req);
            pcmt_pkg::result_t r;
            logic [TBITS-1:0]  longest;
            bit own_out;
            bit all_out;
            int src;
            r       = '0;
            longest = '0;
            own_out = 1'b0;
            all_out = 1'b0;
            src     = int'(req.source);
            if (req.action == pcmt_pkg::ACT_COMMAND)
            begin
                if (src >= active_sources())
                    r.bad_source = 1'b1;
                else
                begin
                    // any good command restarts the global countdown at twice the longest
                    for (int i = 0; i < active_sources(); i++)
                        if (timeout_of(i) > longest)
                            longest = timeout_of(i);
                    all_left    = {longest, 1'b0};
                    all_running = 1'b1;
                    if (!holding || holder == req.source || prio_of(src) > prio_of(holder))
                    begin
                        if (!holding || holder != req.source)
                        begin
                            r.owner_changed = 1'b1;
                            holding         = 1'b1;
                            holder          = req.source;
                        end
                        r.forward     = 1'b1;
                        r.out_payload = req.payload;
                    end
                    if (holding && holder == req.source)
                        holder_left = timeout_of(src);
                end
            end
            else
            begin
                if (holding)
                begin
                    if (holder_left <= 1)
                        own_out = 1'b1;
                    else
                        holder_left--;
                end
                if (all_running)
                begin
                    if (all_left <= 1)
                    begin
                        all_out     = 1'b1;
                        all_running = 1'b0;
                        all_left    = '0;
                    end
                    else
                        all_left--;
                end
                // owner countdown wins when both run out together
                if (holding && (own_out || all_out))
                begin
                    r.went_idle         = 1'b1;
                    r.by_global_timeout = !own_out;
                    holding             = 1'b0;
                    holder              = '0;
                    holder_left         = '0;
                end
            end
            r.owner_valid = holding;
            r.owner       = holding ? holder : '0;
            return r;
        endfunction

        function void note_request(pcmt_pkg::in_item_t req);
            expected_results.push_back(predict_result(req));
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 40)
                $display("[%0t] MISMATCH %s", $time, msg);
        endtask

        task check_field(string name, logic [pcmt_pkg::PAYLOAD_W-1:0] got,
                         logic [pcmt_pkg::PAYLOAD_W-1:0] want);
            if (got !== want)
                report($sformatf("result %0d: %s got %0h want %0h", checked, name, got, want));
        endtask

        task check_result(pcmt_pkg::result_t got);
            pcmt_pkg::result_t want;
            if (expected_results.size() == 0)
            begin
                report($sformatf("result with nothing outstanding: %h", got));
                return;
            end
            want = expected_results.pop_front();
            checked++;
            check_field("forward", got.forward, want.forward);
            check_field("out_payload", got.out_payload, want.out_payload);
            check_field("owner_changed", got.owner_changed, want.owner_changed);
            check_field("owner_valid", got.owner_valid, want.owner_valid);
            check_field("owner", got.owner, want.owner);
            check_field("went_idle", got.went_idle, want.went_idle);
            check_field("by_global_timeout", got.by_global_timeout, want.by_global_timeout);
            check_field("bad_source", got.bad_source, want.bad_source);
        endtask
    endclass

    logic                             clk;
    logic                             rst_n     = 1'b0;
    logic                             cfg_write = 1'b0;
    logic [pcmt_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [pcmt_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                             in_valid  = 1'b0;
    logic                             in_stall;
    pcmt_pkg::in_item_t               in_item   = '0;
    logic                             out_valid;
    logic                             out_stall = 1'b0;
    pcmt_pkg::result_t                out_item;

    ownership_scoreboard sb;
    int                  burst_left = 0;
    int                  cur_active = 0;
    int                  quiet_cycles = 0;
    logic [6:0]          stall_phase = '0;
    int                  stall_mode = 0;

    priority_command_mux_timeout DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Result side: stall pattern switches style each time stall_phase wraps
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            stall_phase <= stall_phase + 1'b1;
            if (stall_phase == 0)
                stall_mode <= $urandom_range(0, 3);
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                2: out_stall <= ($urandom_range(0, 1) == 0);
                default: out_stall <= (stall_phase[4:2] == 3'b101);
            endcase
        end
    end

    // Monitor and no-progress watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_request(in_item);
            if (out_valid && !out_stall)
                sb.check_result(out_item);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("[%0t] no request moved for %0d cycles", $time, STALL_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Send one request; bursts end with a random gap
    task automatic send_request(input pcmt_pkg::in_item_t req);
        int gap;
        in_valid <= 1'b1;
        in_item  <= req;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
            gap = $urandom_range(1, 6);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_all_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    // Registers change only with the mux drained; settle time covers the longest-timeout refresh
    task automatic load_config(input logic [pcmt_pkg::COUNT_W-1:0] count,
                               input logic [pcmt_pkg::PRIO_TABLE_W-1:0] prio,
                               input logic [pcmt_pkg::CFG_DATA_W-1:0] lo,
                               input logic [pcmt_pkg::CFG_DATA_W-1:0] hi);
        pcmt_pkg::cfg_reg_t              regs [4];
        logic [pcmt_pkg::CFG_DATA_W-1:0] vals [4];
        regs = '{pcmt_pkg::CFG_SOURCES_IN_USE, pcmt_pkg::CFG_PRIORITY_TABLE,
                 pcmt_pkg::CFG_TIMEOUTS_LOW, pcmt_pkg::CFG_TIMEOUTS_HIGH};
        vals = '{pcmt_pkg::CFG_DATA_W'(count), pcmt_pkg::CFG_DATA_W'(prio), lo, hi};
        wait_all_results();
        repeat (4) @(posedge clk);
        cfg_write <= 1'b1;
        for (int i = 0; i < 4; i++)
        begin
            cfg_index <= regs[i];
            cfg_data  <= vals[i];
            @(posedge clk);
            sb.set_reg(regs[i], vals[i]);
        end
        cfg_write <= 1'b0;
        cur_active = (count > NSRC) ? NSRC : int'(count);
        repeat (4) @(posedge clk);
    endtask

    task automatic random_config();
        logic [pcmt_pkg::COUNT_W-1:0]      count;
        logic [pcmt_pkg::PRIO_TABLE_W-1:0] prio;
        logic [pcmt_pkg::TMO_WORD_W-1:0]   tmo;
        int                                r;
        r = $urandom_range(0, 19);
        if (r == 0)
            count = '0;
        else if (r == 1)
            count = pcmt_pkg::COUNT_W'($urandom_range(9, 15));
        else
            count = pcmt_pkg::COUNT_W'($urandom_range(1, NSRC));
        // sparse tables make equal priorities common
        prio = $urandom;
        if ($urandom_range(0, 2) == 0)
            prio = prio & 32'h1111_1111;
        // mostly short timeouts so owners expire often
        for (int i = 0; i < NSRC; i++)
        begin
            r = $urandom_range(0, 9);
            if (r == 0)
                tmo[i*TBITS +: TBITS] = '1;
            else if (r == 1)
                tmo[i*TBITS +: TBITS] = TBITS'($urandom);
            else
                tmo[i*TBITS +: TBITS] = TBITS'($urandom_range(0, 8));
        end
        load_config(count, prio, tmo[63:0], tmo[127:64]);
    endtask

    function automatic pcmt_pkg::in_item_t cmd(input int src,
                                               input logic [pcmt_pkg::PAYLOAD_W-1:0] data);
        pcmt_pkg::in_item_t req;
        req.action  = pcmt_pkg::ACT_COMMAND;
        req.source  = pcmt_pkg::SRC_W'(src);
        req.payload = data;
        return req;
    endfunction

    function automatic pcmt_pkg::in_item_t tick();
        pcmt_pkg::in_item_t req;
        req.action  = pcmt_pkg::ACT_TICK;
        req.source  = pcmt_pkg::SRC_W'($urandom);
        req.payload = {$urandom, $urandom};
        return req;
    endfunction

    // Mostly commands, most from sources in use and some from random sources; the rest ticks
    function automatic pcmt_pkg::in_item_t random_request();
        pcmt_pkg::in_item_t req;
        int                 pick;
        req = tick();
        pick = $urandom_range(0, 15);
        if (pick == 0)
            req.payload = '1;
        else if (pick == 1)
            req.payload = '0;
        if ($urandom_range(0, 9) >= 4)
        begin
            req.action = pcmt_pkg::ACT_COMMAND;
            if (cur_active > 0 && $urandom_range(0, 9) < 8)
                req.source = pcmt_pkg::SRC_W'($urandom_range(0, cur_active - 1));
        end
        return req;
    endfunction

    initial
    begin
        sb = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // equal and higher priority, owner expiry, bad sources, silent global expiry
        load_config(4'd4, 32'h0000_F022, 64'h0002_0000_0001_0003, 64'hFFFF_0000_0000_0000);
        send_request(tick());
        send_request(cmd(0, '0));
        send_request(cmd(1, '1));
        send_request(cmd(0, '1));
        repeat (3) send_request(tick());
        send_request(cmd(4, 64'h0123_4567_89AB_CDEF));
        send_request(cmd(7, '1));
        send_request(cmd(2, 64'hA5A5_A5A5_5A5A_5A5A));
        send_request(cmd(3, 64'h8000_0000_0000_0001));
        send_request(cmd(2, 64'h7FFF_FFFF_FFFF_FFFE));
        repeat (6) send_request(tick());

        // count above the source slots; zero timeouts run out together
        load_config(4'd15, '1, '0, '0);
        send_request(cmd(6, 64'h5555_5555_5555_5555));
        send_request(tick());

        // long owner, then it leaves the in-use range and falls to the global countdown
        load_config(4'd8, '1, 64'hAAAA_AAAA_AAAA_AAAA, 64'hFFFF_0000_0000_0000);
        send_request(cmd(7, 64'hFEDC_BA98_7654_3210));
        load_config(4'd1, '0, 64'd1, '0);
        send_request(cmd(0, '1));
        send_request(cmd(3, '0));
        send_request(tick());
        send_request(tick());

        // no sources in use: every command dropped
        load_config(4'd0, 32'h1234_5678, '1, '1);
        send_request(cmd(0, '1));
        send_request(tick());

        // random phases, each with its own settings
        for (int phase = 0; phase < 12; phase++)
        begin
            random_config();
            for (int n = 0; n < 100; n++)
            begin
                if (n == 50 && $urandom_range(0, 3) == 0)
                    wait_all_results();
                send_request(random_request());
            end
        end

        wait_all_results();
        repeat (8) @(posedge clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending()));
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: files.f
sv/pcmt_pkg.sv
sv/priority_command_mux_timeout.sv
dv/tb_priority_command_mux_timeout.sv
